// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the motion event rate alert modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define MERA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that an expression never holds outside of reset.
`define MERA_ASSERT_NEVER(label, expr, msg) \
	`MERA_ASSERT(label, !(expr), msg)

`endif

// ===== rtl/mera_pkg.sv =====
// Shared types and constants of the motion event rate alert.
package mera_pkg;

	localparam int unsigned DEF_HISTORY_DEPTH = 10;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned DEBOUNCE_W = 16;
	localparam int unsigned INTERVAL_W = 20;
	localparam int unsigned WINDOW_W   = 20;
	localparam int unsigned THRESH_W   = 4;
	localparam int unsigned COUNT_W    = 4;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 2'd3;

	localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE = 16'd3000;
	localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 20'd1000;
	localparam logic [WINDOW_W-1:0]   RST_WINDOW   = 20'd20000;
	localparam logic [THRESH_W-1:0]   RST_THRESH   = 4'd3;

	localparam logic OP_DETECT = 1'b0;
	localparam logic OP_SCAN   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic scan_step;
		logic scan_end;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_go;
		logic scan_done;
	} dp_sts_t;

endpackage

// ===== rtl/mera_dp.sv =====
// Datapath: configuration, history memory, time checks and result register.
`include "assert_macros.svh"

module mera_dp #(
	parameter int unsigned HISTORY_DEPTH = mera_pkg::DEF_HISTORY_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mera_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mera_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                operation,
	input  logic [mera_pkg::TIME_W-1:0]         time_ms,
	input  mera_pkg::dp_cmd_t                   cmd,
	output mera_pkg::dp_sts_t                   sts,
	output logic                                accepted,
	output logic                                scanned,
	output logic [mera_pkg::COUNT_W-1:0]        recent_count,
	output logic                                high_alert
);
	import mera_pkg::*;

	localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [WINDOW_W-1:0]   window_q;
	logic [THRESH_W-1:0]   thresh_q;

	logic              op_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] last_accept_q;
	logic [TIME_W-1:0] last_scan_q;

	logic [TIME_W-1:0] mem [HISTORY_DEPTH];
	logic [TIME_W-1:0] rd_data_s1;
	logic              rd_valid_s1;

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] issued_q;
	logic [CNT_W-1:0] kept_q;
	logic             res_acc_q;
	logic             res_scan_q;

	logic              accepted_q;
	logic              scanned_q;
	logic [COUNT_W-1:0] count_q;
	logic              alert_q;

	logic [TIME_W-1:0] accept_age;
	logic [TIME_W-1:0] scan_age;
	logic [TIME_W-1:0] entry_age;
	logic              det_ok;
	logic              scan_ok;
	logic              keep;
	logic              issue;
	logic              append;
	logic              full;
	logic              mem_we;
	logic [PTR_W-1:0]  mem_waddr;
	logic [TIME_W-1:0] mem_wdata;
	logic [CMP_W-1:0]  kept_ext;
	logic [CMP_W-1:0]  thresh_ext;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Elapsed times use wrapping unsigned subtraction.
	assign accept_age = now_q - last_accept_q;
	assign scan_age   = now_q - last_scan_q;
	assign entry_age  = now_q - rd_data_s1;
	assign det_ok     = accept_age >= TIME_W'(debounce_q);
	assign scan_ok    = scan_age >= TIME_W'(interval_q);
	assign keep       = rd_valid_s1 && (entry_age <= TIME_W'(window_q));
	assign full       = fill_q == CNT_W'(HISTORY_DEPTH);
	assign issue      = cmd.scan_step && (issued_q < fill_q);
	assign append     = cmd.decide && (op_q == OP_DETECT) && det_ok;

	assign mem_we    = append || (cmd.scan_step && keep);
	assign mem_waddr = append ? tail_q : wr_ptr_q;
	assign mem_wdata = append ? now_q : rd_data_s1;

	assign sts.scan_go   = (op_q == OP_SCAN) && scan_ok;
	assign sts.scan_done = (issued_q == fill_q) && !rd_valid_s1;

	assign kept_ext   = CMP_W'(kept_q);
	assign thresh_ext = CMP_W'(thresh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= RST_DEBOUNCE;
			interval_q <= RST_INTERVAL;
			window_q   <= RST_WINDOW;
			thresh_q   <= RST_THRESH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data[DEBOUNCE_W-1:0];
				CFG_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				CFG_WINDOW:   window_q   <= cfg_data[WINDOW_W-1:0];
				CFG_THRESH:   thresh_q   <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// History memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			now_q <= time_ms;
		end
		if (cmd.out_load) begin
			accepted_q <= res_acc_q;
			scanned_q  <= res_scan_q;
			count_q    <= (kept_ext > CMP_W'(15)) ? 4'hF : kept_ext[COUNT_W-1:0];
			alert_q    <= res_scan_q && (kept_ext >= thresh_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_accept_q <= '0;
			last_scan_q   <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			fill_q        <= '0;
			issued_q      <= '0;
			kept_q        <= '0;
			rd_valid_s1   <= 1'b0;
			res_acc_q     <= 1'b0;
			res_scan_q    <= 1'b0;
		end else begin
			if (cmd.decide) begin
				res_acc_q  <= append;
				res_scan_q <= sts.scan_go;
				kept_q     <= '0;
				if (append) begin
					// A full history drops its oldest entry by moving the head.
					last_accept_q <= now_q;
					tail_q        <= ptr_inc(tail_q);
					if (full) begin
						head_q <= ptr_inc(head_q);
					end else begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end
				if (sts.scan_go) begin
					last_scan_q <= now_q;
					rd_ptr_q    <= head_q;
					wr_ptr_q    <= head_q;
					issued_q    <= '0;
					rd_valid_s1 <= 1'b0;
				end
			end
			if (cmd.scan_step) begin
				rd_valid_s1 <= issue;
				if (issue) begin
					rd_ptr_q <= ptr_inc(rd_ptr_q);
					issued_q <= issued_q + CNT_W'(1);
				end
				if (keep) begin
					wr_ptr_q <= ptr_inc(wr_ptr_q);
					kept_q   <= kept_q + CNT_W'(1);
				end
			end
			if (cmd.scan_end) begin
				fill_q <= kept_q;
				tail_q <= wr_ptr_q;
			end
		end
	end

	assign accepted     = accepted_q;
	assign scanned      = scanned_q;
	assign recent_count = count_q;
	assign high_alert   = alert_q;

	`MERA_ASSERT(a_fill_bound, fill_q <= CNT_W'(HISTORY_DEPTH), "history fill above depth")
	`MERA_ASSERT(a_kept_bound, kept_q <= issued_q, "more entries kept than read")
	`MERA_ASSERT_NEVER(a_append_in_scan, append && cmd.scan_step, "append during a scan")

endmodule

// ===== rtl/mera_ctrl.sv =====
// Controller: sequences decision, history scan and result handoff.
`include "assert_macros.svh"

module mera_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mera_pkg::dp_sts_t sts,
	output mera_pkg::dp_cmd_t cmd
);
	import mera_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.scan_go ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					cmd.scan_end = 1'b1;
					state_d      = ST_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`MERA_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_q || out_ready), "result overwritten")
	`MERA_ASSERT(a_accept_decide, (in_valid && in_ready) |=> (state_q == ST_DECIDE), "no decide")
	`MERA_ASSERT(a_finish_entry, (state_q == ST_FINISH) |-> ($past(state_q) != ST_IDLE), "bad finish")

endmodule

// ===== rtl/motion_event_rate_alert.sv =====
// Top level of the motion event rate alert: controller plus datapath.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid / in_ready       operation, time_ms
// out      output     out_valid / out_ready     accepted, scanned, recent_count, high_alert
// cfg      input      cfg_we (no wait)          cfg_index, cfg_data
//
// A detection, or a scan that comes too early, passes through the decide and
// finish steps before the next item is accepted. A performed scan adds a scan
// step between them: the scan walks the history memory through its single read
// port, one entry a cycle, and writes the entries it keeps back in order. Reset
// clears the history fill and both time stamps at once; no clearing pass is
// needed. A result that is not taken stalls the block only in its last step, so
// the next item is accepted while the previous result still waits.
//
// Elapsed times are wrapping 32-bit unsigned differences. The history is a
// circular buffer: a detection into a full history overwrites the oldest entry
// and moves the head, and a scan compacts surviving entries toward the head.

module motion_event_rate_alert #(
	parameter int unsigned HISTORY_DEPTH = mera_pkg::DEF_HISTORY_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mera_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mera_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [mera_pkg::TIME_W-1:0]     time_ms,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            accepted,
	output logic                            scanned,
	output logic [mera_pkg::COUNT_W-1:0]    recent_count,
	output logic                            high_alert
);
	import mera_pkg::*;

	// Commands from the controller and status back from the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;

	mera_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the configuration, the history and the result item.
	mera_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.time_ms      (time_ms),
		.cmd          (cmd),
		.sts          (sts),
		.accepted     (accepted),
		.scanned      (scanned),
		.recent_count (recent_count),
		.high_alert   (high_alert)
	);

endmodule
